[sv/longest_palindromic_substring_macros.svh]
// assertion macros for the longest palindromic substring block
`ifndef LONGEST_PALINDROMIC_SUBSTRING_MACROS_SVH
`define LONGEST_PALINDROMIC_SUBSTRING_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lps same-cycle check failed");
// next-cycle implication
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lps next-cycle check failed");
`else
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/lps_pkg.sv]
// shared constants and controller/datapath types for the palindrome search
`default_nettype none
package lps_pkg;

    localparam int MAX_LEN_DEF = 4096;
    localparam int CH_W        = 8;
    localparam int START_W     = 12;
    localparam int LEN_W       = 13;

    typedef struct packed {
        logic load;         // input channel open
        logic init;         // start search over the loaded string
        logic center;       // begin a new center
        logic set_x_edge;   // expansion starts at the rim of the current palindrome
        logic x_inc;        // one more matching step
        logic fin_mirror;   // reach copied from the mirror center
        logic fin_expand;   // reach from expansion, becomes the new center
        logic load_result;  // move best into the output register
    } lps_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic covered;
        logic mirror_ok;
        logic can_expand;
        logic sep_step;
        logic chars_eq;
        logic last_center;
        logic out_free;
    } lps_sts_t;

endpackage
`default_nettype wire

[sv/lps_in_if.sv]
// input channel: one string character per transfer
`default_nettype none
interface lps_in_if;
    import lps_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

[sv/lps_out_if.sv]
// output channel: one search result per transfer
`default_nettype none
interface lps_out_if;
    import lps_pkg::*;

    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic               overflow;

    modport source (output valid, output start_res, output length, output overflow,
                    input ready);
    modport sink   (input valid, input start_res, input length, input overflow,
                    output ready);
endinterface
`default_nettype wire

[sv/lps_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/lps_ctrl.sv]
// sequencer for loading, per-center reach search and result hand-off
`default_nettype none
module lps_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lps_pkg::lps_sts_t sts,
    output lps_pkg::lps_cmd_t      cmd
);
    import lps_pkg::*;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_CENTER = 3'd2;
    localparam logic [2:0] ST_MIRROR = 3'd3;
    localparam logic [2:0] ST_EXPAND = 3'd4;
    localparam logic [2:0] ST_CMP    = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] after_fin;

    // where to go once a center's reach is settled
    assign after_fin = sts.last_center ? ST_DRAIN : ST_CENTER;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (sts.in_fire && sts.in_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_CENTER;
            end
            ST_CENTER:
            begin
                cmd.center = 1'b1;
                state_next = sts.covered ? ST_MIRROR : ST_EXPAND;
            end
            ST_MIRROR:
            begin
                if (sts.mirror_ok)
                begin
                    cmd.fin_mirror = 1'b1;
                    state_next     = after_fin;
                end
                else
                begin
                    cmd.set_x_edge = 1'b1;
                    state_next     = ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (!sts.can_expand)
                begin
                    cmd.fin_expand = 1'b1;
                    state_next     = after_fin;
                end
                else if (sts.sep_step)
                begin
                    // separators always match
                    cmd.x_inc = 1'b1;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.chars_eq)
                begin
                    cmd.x_inc  = 1'b1;
                    state_next = ST_EXPAND;
                end
                else
                begin
                    cmd.fin_expand = 1'b1;
                    state_next     = after_fin;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[sv/lps_dp.sv]
// datapath: character and reach stores, center tracking, best-result tracking
`default_nettype none
module lps_dp #(
    parameter int MAX_LEN = lps_pkg::MAX_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lps_pkg::lps_cmd_t cmd,
    output lps_pkg::lps_sts_t      sts,
    lps_in_if.sink                 in_ch,
    lps_out_if.source              out_ch
);
    import lps_pkg::*;

    localparam int IW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int PW    = IW + 1;
    localparam int DEPTH = 2 * MAX_LEN - 1;

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [PW-1:0]      total_reg, total_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      x_reg, x_next;
    logic               c_valid_reg, c_valid_next;
    logic [PW-1:0]      c_pos_reg, c_pos_next;
    logic [PW-1:0]      c_reach_reg, c_reach_next;
    logic               fin_valid_reg, fin_valid_next;
    logic [PW-1:0]      fin_pos_reg, fin_pos_next;
    logic [PW-1:0]      fin_reach_reg, fin_reach_next;
    logic [IW-1:0]      best_start_reg, best_start_next;
    logic [CW-1:0]      best_len_reg, best_len_next;
    logic               out_valid_reg, out_valid_next;
    logic [START_W-1:0] out_start_reg, out_start_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               in_fire;
    logic               room;
    logic               fin;
    logic [PW:0]        rim;
    logic [PW-1:0]      mir_addr;
    logic [PW-1:0]      mir_reach;
    logic [PW-1:0]      lo_pos;
    logic [PW:0]        hi_pos;
    logic [CH_W-1:0]    lo_ch;
    logic [CH_W-1:0]    hi_ch;
    logic [PW-1:0]      half_odd;
    logic [PW-1:0]      half;
    logic [PW:0]        cand_len;
    logic [PW-1:0]      cand_start;
    logic               better;
    logic [PW-1:0]      reach_wdata;

    // handshakes
    assign in_ch.ready = cmd.load;
    assign in_fire     = in_ch.valid && cmd.load;
    assign room        = cnt_reg < CW'(MAX_LEN);
    assign fin         = cmd.fin_mirror || cmd.fin_expand;

    // rightmost palindrome and mirror center
    assign rim      = {1'b0, c_pos_reg} + {1'b0, c_reach_reg};
    assign mir_addr = PW'({c_pos_reg, 1'b0} - {1'b0, pos_reg});

    // expansion probes
    assign lo_pos = pos_reg - x_reg - PW'(1);
    assign hi_pos = {1'b0, pos_reg} + {1'b0, x_reg} + (PW+1)'(1);

    assign reach_wdata = cmd.fin_mirror ? mir_reach : x_reg;

    lps_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_char_lo (
        .clk   (clk),
        .we    (in_fire && room),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (in_ch.ch),
        .raddr (lo_pos[PW-1:1]),
        .rdata (lo_ch)
    );

    // copy of the character store for the second compare operand
    lps_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_char_hi (
        .clk   (clk),
        .we    (in_fire && room),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (in_ch.ch),
        .raddr (hi_pos[PW-1:1]),
        .rdata (hi_ch)
    );

    lps_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_reach (
        .clk   (clk),
        .we    (fin),
        .waddr (pos_reg),
        .wdata (reach_wdata),
        .raddr (mir_addr),
        .rdata (mir_reach)
    );

    // status
    always_comb
    begin
        sts             = '0;
        sts.in_fire     = in_fire;
        sts.in_last     = in_ch.last;
        sts.covered     = c_valid_reg && (rim > {1'b0, pos_reg});
        sts.mirror_ok   = ({1'b0, pos_reg} + {1'b0, mir_reach}) < rim;
        sts.can_expand  = (pos_reg > x_reg) && (hi_pos < {1'b0, total_reg});
        sts.sep_step    = ~(pos_reg[0] ^ x_reg[0]);
        sts.chars_eq    = lo_ch == hi_ch;
        sts.last_center = pos_reg == (total_reg - PW'(1));
        sts.out_free    = !out_valid_reg || out_ch.ready;
    end

    // candidate from the reach settled in the previous cycle
    assign half_odd   = PW'(({1'b0, fin_reach_reg} + (PW+1)'(1)) >> 1);
    assign half       = fin_pos_reg[0] ? half_odd : (fin_reach_reg >> 1);
    assign cand_len   = fin_pos_reg[0] ? {half, 1'b0} : {half, 1'b1};
    assign cand_start = PW'(({1'b0, fin_pos_reg} + (PW+1)'(1)) >> 1) - half;
    assign better     = fin_valid_reg && (cand_len > (PW+1)'(best_len_reg));

    always_comb
    begin
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        x_next          = x_reg;
        c_valid_next    = c_valid_reg;
        c_pos_next      = c_pos_reg;
        c_reach_next    = c_reach_reg;
        fin_valid_next  = fin;
        fin_pos_next    = pos_reg;
        fin_reach_next  = reach_wdata;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        out_valid_next  = out_valid_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;

        if (in_fire)
        begin
            if (room)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.init)
        begin
            total_next      = PW'({1'b0, cnt_reg, 1'b0} - (CW+2)'(1));
            pos_next        = '0;
            c_valid_next    = 1'b0;
            best_start_next = '0;
            best_len_next   = CW'(1);
        end

        if (cmd.center)
        begin
            x_next = '0;
        end
        if (cmd.set_x_edge)
        begin
            x_next = PW'(rim - {1'b0, pos_reg});
        end
        if (cmd.x_inc)
        begin
            x_next = x_reg + PW'(1);
        end

        if (fin)
        begin
            pos_next = pos_reg + PW'(1);
        end
        if (cmd.fin_expand)
        begin
            c_valid_next = 1'b1;
            c_pos_next   = pos_reg;
            c_reach_next = x_reg;
        end

        if (better)
        begin
            best_start_next = cand_start[IW-1:0];
            best_len_next   = CW'(cand_len);
        end

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
            out_start_next = START_W'(best_start_reg);
            out_len_next   = LEN_W'(best_len_reg);
            out_ovf_next   = ovf_reg;
            cnt_next       = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            c_valid_reg    <= 1'b0;
            fin_valid_reg  <= 1'b0;
            best_start_reg <= '0;
            best_len_reg   <= CW'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            c_valid_reg    <= c_valid_next;
            fin_valid_reg  <= fin_valid_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        pos_reg       <= pos_next;
        x_reg         <= x_next;
        c_pos_reg     <= c_pos_next;
        c_reach_reg   <= c_reach_next;
        fin_pos_reg   <= fin_pos_next;
        fin_reach_reg <= fin_reach_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.start_res = out_start_reg;
    assign out_ch.length    = out_len_reg;
    assign out_ch.overflow  = out_ovf_reg;

endmodule
`default_nettype wire

[sv/longest_palindromic_substring.sv]
// Longest palindromic substring finder, top level.
// Characters arrive one per transfer on in_ch (ch, last); the transfer with
// last high closes the string. Up to MAX_LEN characters are kept; later ones
// are dropped and the overflow bit of the result is set.
// After the last character the block runs Manacher's scheme over 2n-1 centers
// (characters and the gaps between them), after a setup step. Each center is
// fetched and then settled, from the mirror reach or by expansion; when a
// mirror reach falls short, expansion resumes from the rim. Gap steps always
// match; a character step compares reads of both character stores. Expansion
// steps are bounded by 2n overall. The result (start_res, length, overflow)
// lands in an output register after the last center; in_ch reopens in the
// same cycle.
// While out_ch is stalled a new string can load; its result waits until the
// held one is taken.
// Reset (rst_n, asynchronous, low) empties the string and drops any pending
// result; the stores need no clearing, so in_ch is ready right after reset.
`default_nettype none
`include "longest_palindromic_substring_macros.svh"
module longest_palindromic_substring #(
    parameter int MAX_LEN = lps_pkg::MAX_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lps_in_if.sink    in_ch,
    lps_out_if.source out_ch
);
    import lps_pkg::*;

    lps_cmd_t cmd;
    lps_sts_t sts;
    logic     busy_cmd;

    lps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lps_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    assign busy_cmd = cmd.fin_mirror || cmd.fin_expand || cmd.x_inc || cmd.load_result;

    // loading never overlaps search steps or result hand-off
    `LPS_ASSERT_IMP(a_load_excl, clk, rst_n, cmd.load, !busy_cmd)
    // a held result is never overwritten
    `LPS_ASSERT_IMP(a_result_free, clk, rst_n, cmd.load_result, sts.out_free)
    `LPS_ASSERT_NXT(a_valid_after_load, clk, rst_n, cmd.load_result, out_ch.valid)
    `LPS_ASSERT_IMP(a_valid_source, clk, rst_n, $rose(out_ch.valid), $past(cmd.load_result))

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// testbench for the longest palindromic substring block: random strings, self-checking
`default_nettype none
module testbench;
    import lps_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            last;
        bit              hold;
    } char_item_t;

    typedef struct packed {
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        logic               overflow;
    } best_t;

    typedef enum int {MIX_RANDOM, MIX_TWO, MIX_PLANTED, MIX_THREE} mix_kind_t;

    logic clk;
    logic rst_n;

    lps_in_if  in_ch ();
    lps_out_if out_ch ();

    longest_palindromic_substring u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // string loader and predicted results
    char_item_t      char_q[$];
    best_t           best_q[$];
    logic [CH_W-1:0] str_buf[$];
    int              queued_cnt;
    int              accepted_cnt;
    int              err_count;

    // predictor state
    logic [CH_W-1:0] text_mem [MAX_LEN];
    int              reach_mem [2*MAX_LEN-1];
    int              text_cnt;
    bit              text_ovf;

    // driver and receiver pacing
    char_item_t drv_item;
    int         burst_left;
    int         gap_left;
    int         stall_left;
    int         quiet_left;

    task report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // manacher over the separator-filled positions, first longest wins
    task automatic search_palindrome();
        int    total;
        int    i;
        int    k;
        int    ctr;
        int    lim;
        int    lo;
        int    cstart;
        int    clen;
        int    best_start;
        int    best_len;
        best_t res;
        total      = 2 * text_cnt - 1;
        ctr        = -1;
        best_start = 0;
        best_len   = 1;
        for (i = 0; i < total; i++)
        begin
            k = 0;
            if (ctr >= 0 && ctr + reach_mem[ctr] > i)
            begin
                lim = ctr + reach_mem[ctr] - i;
                k   = reach_mem[2 * ctr - i];
                if (k > lim)
                    k = lim;
            end
            // separators always match each other
            while (i - k - 1 >= 0 && i + k + 1 < total &&
                   (((i - k - 1) % 2) == 1 ||
                    text_mem[(i - k - 1) / 2] == text_mem[(i + k + 1) / 2]))
                k++;
            reach_mem[i] = k;
            if (ctr < 0 || i + k > ctr + reach_mem[ctr])
                ctr = i;
            lo     = i - k;
            cstart = (lo + 1) / 2;
            clen   = (i + k) / 2 - cstart + 1;
            if (clen > best_len)
            begin
                best_len   = clen;
                best_start = cstart;
            end
        end
        res.start_res = best_start[START_W-1:0];
        res.length    = best_len[LEN_W-1:0];
        res.overflow  = text_ovf;
        best_q.insert(best_q.size(), res);
        text_cnt = 0;
        text_ovf = 1'b0;
    endtask

    task predict_char(input logic [CH_W-1:0] c, input logic l);
        if (text_cnt < MAX_LEN)
        begin
            text_mem[text_cnt] = c;
            text_cnt++;
        end
        else
            text_ovf = 1'b1;
        accepted_cnt++;
        if (l)
            search_palindrome();
    endtask

    task queue_string(input bit hold);
        char_item_t it;
        for (int j = 0; j < str_buf.size(); j++)
        begin
            it.ch   = str_buf[j];
            it.last = (j == str_buf.size() - 1);
            it.hold = hold && (j == 0);
            char_q.insert(char_q.size(), it);
            queued_cnt++;
        end
        str_buf.delete();
    endtask

    task drv_check(input best_t want);
        if (out_ch.start_res !== want.start_res)
            report_error($sformatf("start_res got %0d want %0d",
                                   out_ch.start_res, want.start_res));
        if (out_ch.length !== want.length)
            report_error($sformatf("length got %0d want %0d", out_ch.length, want.length));
        if (out_ch.overflow !== want.overflow)
            report_error($sformatf("overflow got %0d want %0d",
                                   out_ch.overflow, want.overflow));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.ch     = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #8000000;
        $display("longest_palindromic_substring test failed");
        $finish;
    end

    // sender: bursts with random gaps, optional hold until all results are in
    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_char(in_ch.ch, in_ch.last);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (char_q.size() == 0 || (char_q[0].hold && best_q.size() != 0))
                    in_ch.valid <= 1'b0;
                else
                begin
                    drv_item = char_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.ch    <= drv_item.ch;
                    in_ch.last  <= drv_item.last;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver stall pattern with quiet stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 20);
                if ($urandom_range(0, 4) == 0)
                    quiet_left = $urandom_range(20, 200);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (best_q.size() == 0)
                report_error($sformatf("unexpected result start=%0d length=%0d overflow=%0d",
                                       out_ch.start_res, out_ch.length, out_ch.overflow));
            else
            begin
                drv_check(best_q.pop_front());
            end
        end
    end

    initial
    begin : stimulus
        int        rand_items;
        int        n;
        int        r;
        int        plen;
        int        pos;
        bit        big_done;
        mix_kind_t kind;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        queued_cnt   = 0;
        accepted_cnt = 0;
        err_count    = 0;
        text_cnt     = 0;
        text_ovf     = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        stall_left   = 0;
        quiet_left   = 0;
        rand_items   = 0;
        big_done     = 1'b0;

        // single characters at both extremes
        str_buf = '{8'h00};
        queue_string(1'b0);
        str_buf = '{8'hff};
        queue_string(1'b0);
        // shortest even palindrome, and a tie of single characters
        str_buf = '{8'h05, 8'h05};
        queue_string(1'b0);
        str_buf = '{8'h01, 8'h02};
        queue_string(1'b0);
        str_buf = '{8'h03, 8'h09, 8'h03};
        queue_string(1'b0);
        str_buf = '{8'haa, 8'h55, 8'h55, 8'haa};
        queue_string(1'b0);
        // two even palindromes of equal length, first one wins
        str_buf = '{8'h01, 8'h02, 8'h02, 8'h03, 8'h03};
        queue_string(1'b0);
        str_buf = '{8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80, 8'h01};
        queue_string(1'b0);

        while (rand_items < 400)
        begin
            if (rand_items >= 200 && !big_done)
            begin
                // a long run of one byte, sent once every pending result is in
                a = CH_W'($urandom_range(0, 255));
                for (int j = 0; j < 48; j++)
                    str_buf.insert(str_buf.size(), a);
                queue_string(1'b1);
                rand_items += 48;
                big_done = 1'b1;
            end
            r = $urandom_range(0, 9);
            if (r < 6)
                n = $urandom_range(1, 8);
            else if (r < 9)
                n = $urandom_range(9, 30);
            else
                n = $urandom_range(31, 80);
            kind = mix_kind_t'($urandom_range(0, 3));
            a    = CH_W'($urandom_range(0, 255));
            b    = CH_W'($urandom_range(0, 255));
            for (int j = 0; j < n; j++)
            begin
                case (kind)
                    MIX_TWO:   str_buf.insert(str_buf.size(), $urandom_range(0, 1) ? a : b);
                    MIX_THREE:
                    begin
                        r = $urandom_range(0, 2);
                        str_buf.insert(str_buf.size(), r == 0 ? a : (r == 1 ? b : ~a));
                    end
                    default:   str_buf.insert(str_buf.size(), CH_W'($urandom_range(0, 255)));
                endcase
            end
            if (kind == MIX_PLANTED)
            begin
                plen = $urandom_range(1, n);
                pos  = $urandom_range(0, n - plen);
                for (int j = 0; j < plen / 2; j++)
                    str_buf[pos + plen - 1 - j] = str_buf[pos + j];
            end
            rand_items += n;
            queue_string($urandom_range(0, 9) == 0);
        end

        @(negedge clk);
        while (accepted_cnt != queued_cnt || best_q.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("longest_palindromic_substring test passed");
        else
            $display("longest_palindromic_substring test failed");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/lps_pkg.sv
sv/lps_in_if.sv
sv/lps_out_if.sv
sv/lps_ram.sv
sv/lps_ctrl.sv
sv/lps_dp.sv
sv/longest_palindromic_substring.sv
tb/sv/testbench.sv
